[rtl/m4vt_pkg.sv]
// m4vt_pkg: shared types and constants of the 4x4 matrix-vector transform unit
// no dependencies; imported by every module under rtl/
package m4vt_pkg;

    localparam int LANES      = 4;
    localparam int NUM_REGS   = 8;
    localparam int WORD_W     = 32;
    localparam int REG_W      = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    typedef logic signed [WORD_W-1:0] q_t;
    typedef q_t [LANES-1:0]           vec_t;
    typedef vec_t [LANES-1:0]         mat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 4'd0,
        REG_ROW0_COLS23 = 4'd1,
        REG_ROW1_COLS01 = 4'd2,
        REG_ROW1_COLS23 = 4'd3,
        REG_ROW2_COLS01 = 4'd4,
        REG_ROW2_COLS23 = 4'd5,
        REG_ROW3_COLS01 = 4'd6,
        REG_ROW3_COLS23 = 4'd7
    } reg_idx_t;

    // load enables of the lane pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

[rtl/matrix4_vector_transform.sv]
// matrix4_vector_transform: top level of the 4x4 matrix times vector unit
// depends on m4vt_pkg, m4vt_matrix, m4vt_lane, m4vt_merge
//
//  channel  signals                              direction  handshake
//  input    in_x in_y in_z in_w                  in         in_valid / in_stall
//  output   out_x out_y out_z out_w saturated    out        out_valid / out_stall
//  config   cfg_index cfg_data                   in         cfg_valid / cfg_ready
//
// one word per cycle sustained while out_stall stays low; an accepted word reaches out_valid through
// the multiply (loaded at the accepting edge), then pair add, final add and merge output register
// each pipeline stage loads when empty or when the stage after it moves, so bubbles close up
// in_stall rises only when all four stages are full and out_stall is high
// reset clears the valid bits and loads the identity matrix; cfg_ready is always high
module matrix4_vector_transform
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WORD_W-1:0] in_x,
    input  logic signed [WORD_W-1:0] in_y,
    input  logic signed [WORD_W-1:0] in_z,
    input  logic signed [WORD_W-1:0] in_w,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] out_x,
    output logic signed [WORD_W-1:0] out_y,
    output logic signed [WORD_W-1:0] out_z,
    output logic signed [WORD_W-1:0] out_w,
    output logic                     saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [REG_W-1:0]         cfg_data
);

    mat_t             mat;
    vec_t             vec;
    vec_t             lane_result;
    logic [LANES-1:0] lane_sat;
    pipe_en_t         en;
    logic             v1_reg, v2_reg, v3_reg;
    logic             v1_next, v2_next, v3_next;
    logic             lanes_take;

    assign cfg_ready = 1'b1;
    assign vec = {in_w, in_z, in_y, in_x};

    always_comb
    begin
        en.s3    = !v3_reg || lanes_take;
        en.s2    = !v2_reg || en.s3;
        en.s1    = !v1_reg || en.s2;
        in_stall = !en.s1;
        v1_next  = en.s1 ? in_valid : v1_reg;
        v2_next  = en.s2 ? v1_reg : v2_reg;
        v3_next  = en.s3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    m4vt_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        m4vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .vec    (vec),
            .row    (mat[i]),
            .result (lane_result[i]),
            .sat    (lane_sat[i])
        );
    end

    m4vt_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_valid (v3_reg),
        .lanes_take  (lanes_take),
        .lane_result (lane_result),
        .lane_sat    (lane_sat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w),
        .saturated   (saturated)
    );

endmodule

[rtl/m4vt_matrix.sv]
// m4vt_matrix: eight 64-bit matrix registers, config write port, identity at reset
// depends on m4vt_pkg
module m4vt_matrix
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output mat_t                 mat
);

    logic [REG_W-1:0] regs_reg [NUM_REGS];

    // identity: diagonal entry of row r sits in register 2r + r/2, half r&1
    function automatic logic [REG_W-1:0] reset_word(input int idx);
        int row;
        logic [REG_W-1:0] one;
        row = idx >> 1;
        one = REG_W'(1) << FRAC_BITS;
        if ((idx & 1) == (row >> 1))
            return ((row & 1) != 0) ? (one << WORD_W) : one;
        return '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= reset_word(i);
            end
        end
        else if (cfg_valid && (cfg_index <= REG_ROW3_COLS23))
        begin
            regs_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                mat[r][c] = regs_reg[2*r + (c >> 1)][WORD_W*(c & 1) +: WORD_W];
            end
        end
    end

endmodule

[rtl/m4vt_lane.sv]
// m4vt_lane: one matrix row dotted with the input vector
// four multipliers, two-level adder tree, floor shift and saturation; depends on m4vt_pkg
module m4vt_lane
    import m4vt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  pipe_en_t en,
    input  vec_t     vec,
    input  vec_t     row,
    output q_t       result,
    output logic     sat
);

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PAIR_W-1:0] pair_reg [LANES/2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-WORD_W:0]    upper;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                prod_reg[j] <= $signed(row[j]) * $signed(vec[j]);
            end
        end
        if (en.s2)
        begin
            for (int k = 0; k < LANES/2; k++)
            begin
                pair_reg[k] <= {prod_reg[2*k][PROD_W-1], prod_reg[2*k]}
                             + {prod_reg[2*k+1][PROD_W-1], prod_reg[2*k+1]};
            end
        end
        if (en.s3)
        begin
            sum_reg <= {pair_reg[0][PAIR_W-1], pair_reg[0]}
                     + {pair_reg[1][PAIR_W-1], pair_reg[1]};
        end
    end

    // arithmetic shift of the exact sum is the floor
    assign shifted = sum_reg >>> FRAC_BITS;
    assign upper   = shifted[SUM_W-1:WORD_W-1];

    always_comb
    begin
        sat    = !((&upper) || !(|upper));
        result = shifted[WORD_W-1:0];
        if (sat)
        begin
            result = shifted[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                      : {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

endmodule

[rtl/m4vt_merge.sv]
// m4vt_merge: output register; collects the four lane results and ors their clip flags
// depends on m4vt_pkg
module m4vt_merge
    import m4vt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    lanes_valid,
    output logic                    lanes_take,
    input  vec_t                    lane_result,
    input  logic [LANES-1:0]        lane_sat,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [WORD_W-1:0] out_x,
    output logic signed [WORD_W-1:0] out_y,
    output logic signed [WORD_W-1:0] out_z,
    output logic signed [WORD_W-1:0] out_w,
    output logic                    saturated
);

    logic valid_reg;
    logic valid_next;
    vec_t result_reg;
    logic sat_reg;

    // word moves in when the register is empty or being drained
    assign lanes_take = !valid_reg || !out_stall;
    assign valid_next = lanes_take ? lanes_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lanes_take)
        begin
            result_reg <= lane_result;
            sat_reg    <= |lane_sat;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = result_reg[0];
    assign out_y     = result_reg[1];
    assign out_z     = result_reg[2];
    assign out_w     = result_reg[3];
    assign saturated = sat_reg;

endmodule

[tb/sv/testbench.sv]
// testbench for matrix4_vector_transform: streams vectors through the 4x4 transform
// and checks every output word against a scoreboard holding its own matrix copy
// depends on m4vt_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module testbench;
    import m4vt_pkg::*;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 4;
    localparam int PHASES   = 8;
    localparam int PHASE_LEN = 205;

    typedef q_t coef_t [LANES][LANES];

    typedef struct packed {
        vec_t lane;
        logic sat;
    } xform_word_t;

    typedef enum int {
        MK_IDENTITY,
        MK_ALL_MAX,
        MK_ALL_MIN,
        MK_DIAG_TWO,
        MK_RANDOM,
        MK_SMALL,
        MK_MIXED
    } matrix_kind_e;

    class xform_scoreboard;
        q_t          coef [LANES][LANES];
        xform_word_t pending_products [$];
        int          errors;
        int          n_checked;
        int          n_sat;

        function new();
            for (int i = 0; i < LANES; i++)
                for (int j = 0; j < LANES; j++)
                    coef[i][j] = (i == j) ? q_t'(1 << FRAC) : '0;
            errors    = 0;
            n_checked = 0;
            n_sat     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
            int row;
            int col;
            if (idx < NUM_REGS)
            begin
                row = idx / 2;
                col = (idx % 2) * 2;
                coef[row][col]     = data[WORD_W-1:0];
                coef[row][col + 1] = data[REG_W-1:WORD_W];
            end
        endfunction

        // exact dot product, floor to FRAC fraction bits, clip to 32 bits
        function xform_word_t transform(vec_t v);
            xform_word_t             r;
            logic signed [SUM_W-1:0] acc;
            logic signed [SUM_W-1:0] q;
            r.sat = 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                acc = '0;
                for (int j = 0; j < LANES; j++)
                    acc = acc + coef[i][j] * $signed(v[j]);
                q = acc >>> FRAC;
                if (q[SUM_W-1:WORD_W-1] != '0 && q[SUM_W-1:WORD_W-1] != '1)
                begin
                    r.lane[i] = q[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                           : {1'b0, {(WORD_W-1){1'b1}}};
                    r.sat = 1'b1;
                end
                else
                    r.lane[i] = q[WORD_W-1:0];
            end
            return r;
        endfunction

        function void note_input(vec_t v);
            pending_products.push_back(transform(v));
        endfunction

        function void check_result(vec_t got, logic got_sat);
            xform_word_t exp_w;
            string       names [LANES];
            names = '{"out_x", "out_y", "out_z", "out_w"};
            if (pending_products.size() == 0)
            begin
                $display("%0t: unexpected word x=%h y=%h z=%h w=%h sat=%b",
                         $time, got[0], got[1], got[2], got[3], got_sat);
                errors++;
                return;
            end
            exp_w = pending_products.pop_front();
            n_checked++;
            if (exp_w.sat)
                n_sat++;
            for (int i = 0; i < LANES; i++)
                if (got[i] !== exp_w.lane[i])
                begin
                    $display("%0t: %s expected %h got %h", $time, names[i],
                             exp_w.lane[i], got[i]);
                    errors++;
                end
            if (got_sat !== exp_w.sat)
            begin
                $display("%0t: saturated expected %b got %b", $time, exp_w.sat, got_sat);
                errors++;
            end
        endfunction

        function int pending();
            return pending_products.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [WORD_W-1:0] in_x;
    logic signed [WORD_W-1:0] in_y;
    logic signed [WORD_W-1:0] in_z;
    logic signed [WORD_W-1:0] in_w;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic signed [WORD_W-1:0] out_w;
    logic                     saturated;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [REG_W-1:0]         cfg_data;

    xform_scoreboard sb = new();

    int gap_pct   = 0;
    int stall_pct = 0;
    int n_sent    = 0;
    int n_loads   = 0;

    matrix4_vector_transform #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_w      (in_w),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // output side: check accepted words, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({out_w, out_z, out_y, out_x}, saturated);
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic q_t rand_word();
        case ($urandom_range(0, 7))
            0: rand_word = {1'b0, {(WORD_W-1){1'b1}}};
            1: rand_word = {1'b1, {(WORD_W-1){1'b0}}};
            2: rand_word = q_t'($urandom_range(0, 4)) - q_t'(2);
            3, 4: rand_word = q_t'($urandom_range(0, 1 << (FRAC + 4))) - q_t'(1 << (FRAC + 3));
            default: rand_word = q_t'($urandom);
        endcase
    endfunction

    function automatic coef_t make_matrix(matrix_kind_e kind);
        coef_t m;
        for (int i = 0; i < LANES; i++)
            for (int j = 0; j < LANES; j++)
                case (kind)
                    MK_IDENTITY: m[i][j] = (i == j) ? q_t'(1 << FRAC) : '0;
                    MK_ALL_MAX:  m[i][j] = {1'b0, {(WORD_W-1){1'b1}}};
                    MK_ALL_MIN:  m[i][j] = {1'b1, {(WORD_W-1){1'b0}}};
                    MK_DIAG_TWO: m[i][j] = (i == j) ? q_t'(2 << FRAC) : q_t'(1);
                    MK_RANDOM:   m[i][j] = q_t'($urandom);
                    MK_SMALL:    m[i][j] = q_t'($urandom_range(0, 4 << FRAC)) - q_t'(2 << FRAC);
                    default:     m[i][j] = rand_word();
                endcase
        return m;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // block must be idle; junk adds one write past the last register, all_junk writes every index past it
    task automatic load_matrix(input coef_t m, input bit junk, input bit all_junk);
        int row;
        int col;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            row = r / 2;
            col = (r % 2) * 2;
            cfg_write(reg_idx_t'(r), {m[row][col + 1], m[row][col]});
        end
        if (all_junk)
            for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
                cfg_write(CFG_IDX_W'(k), {$urandom, $urandom});
        else if (junk)
            cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
                      {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_loads++;
    endtask

    task automatic send_vec(input vec_t v);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_x     <= v[0];
        in_y     <= v[1];
        in_z     <= v[2];
        in_w     <= v[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(v);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        q_t            qmax;
        q_t            qmin;
        q_t            one;
        matrix_kind_e  phase_kind [PHASES];

        qmax = {1'b0, {(WORD_W-1){1'b1}}};
        qmin = {1'b1, {(WORD_W-1){1'b0}}};
        one  = q_t'(1 << FRAC);
        phase_kind = '{MK_SMALL, MK_RANDOM, MK_MIXED, MK_SMALL,
                       MK_IDENTITY, MK_MIXED, MK_RANDOM, MK_SMALL};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_x      = '0;
        in_y      = '0;
        in_z      = '0;
        in_w      = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset
        send_vec({q_t'(0), q_t'(0), q_t'(0), q_t'(0)});
        send_vec({qmax, qmax, qmax, qmax});
        send_vec({qmin, qmin, qmin, qmin});
        send_vec({-one, one, q_t'(-1), q_t'(1)});
        send_vec({q_t'(-1), q_t'(1), qmin, qmax});
        drain();

        // largest products, clipped both ways
        load_matrix(make_matrix(MK_ALL_MAX), 1'b0, 1'b0);
        send_vec({qmax, qmax, qmax, qmax});
        send_vec({qmin, qmin, qmin, qmin});
        send_vec({qmin, qmax, qmin, qmax});
        drain();

        load_matrix(make_matrix(MK_ALL_MIN), 1'b0, 1'b0);
        send_vec({qmin, qmin, qmin, qmin});
        send_vec({qmax, qmax, qmax, qmax});
        send_vec({q_t'(1), q_t'(1), q_t'(1), q_t'(1)});
        drain();

        // one lane just over the top, floor on negative sums, writes past the last register
        load_matrix(make_matrix(MK_DIAG_TWO), 1'b0, 1'b1);
        send_vec({q_t'(0), q_t'(0), q_t'(0), q_t'(32'h4000_0000)});
        send_vec({q_t'(-1), q_t'(-1), q_t'(-1), q_t'(-1)});
        send_vec({q_t'(0), q_t'(0), q_t'(32'hc000_0000), q_t'(0)});
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct   = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 24 : 0;
            stall_pct = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 24 : 0;
            load_matrix(make_matrix(phase_kind[p]), p[0], 1'b0);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // hold off once until the pipe is empty, then resume
                if (p == 1 && n == PHASE_LEN / 2)
                    drain();
                send_vec({rand_word(), rand_word(), rand_word(), rand_word()});
            end
            drain();
        end

        stall_pct = 0;
        $display("covered %0d vectors over %0d matrix loads; %0d words checked, %0d saturated",
                 n_sent, n_loads, sb.n_checked, sb.n_sat);
        $display("loads spanned identity, extreme, small and random matrices plus ignored writes");
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d words outstanding", sb.pending());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
